// ===== sv/hsfc_pkg.sv =====
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants for the half/single float converter.
// ----------------------------------------------------------------------------
`default_nettype none

package hsfc_pkg;

  typedef enum logic {
    OP_HALF_TO_SINGLE = 1'b0,
    OP_SINGLE_TO_HALF = 1'b1
  } op_e;

  localparam logic [15:0] HalfSign    = 16'h8000;
  localparam logic [9:0]  HalfMant    = 10'h3FF;
  localparam int          ExpBiasDiff = 127 - 15;
  localparam logic [12:0] DropHalf    = 13'h1000;
  localparam logic [9:0]  HalfQnanBit = 10'h200;
  localparam logic [4:0]  HalfExpMax  = 5'h1F;

  // input beat
  typedef struct packed {
    op_e         op;
    logic [31:0] operand;
  } in_beat_t;

  // output beat
  typedef struct packed {
    logic [31:0] converted;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== sv/hsfc_stream_if.sv =====
// ----------------------------------------------------------------------------
// hsfc_in_if / hsfc_out_if
// Valid/ready stream interfaces for the converter channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface hsfc_in_if;
  logic              valid;
  logic              ready;
  hsfc_pkg::in_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface hsfc_out_if;
  logic               valid;
  logic               ready;
  hsfc_pkg::out_beat_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== sv/hsfc_convert.sv =====
// ----------------------------------------------------------------------------
// hsfc_convert
// Combinational binary16 <-> binary32 conversion of one operand.
// ----------------------------------------------------------------------------
`default_nettype none

module hsfc_convert (
  input  var hsfc_pkg::in_beat_t beat_i,
  output logic [31:0]            converted_o
);

  logic [31:0] widened;
  logic [15:0] narrowed;

  // half to single
  always_comb begin
    logic [15:0] h;
    logic [4:0]  e;
    logic [9:0]  m;
    logic [3:0]  k;
    logic [10:0] nm;
    logic [7:0]  ew;
    h  = beat_i.operand[15:0];
    e  = h[14:10];
    m  = h[9:0];
    k  = 4'd0;
    for (int i = 9; i >= 0; i--) begin
      if (m[i] && k == 4'd0) k = 4'(10 - i);
    end
    nm = {1'b0, m} << k;
    ew = 8'(1 + hsfc_pkg::ExpBiasDiff) - {4'd0, k};
    widened = {h[15], 31'd0};
    if (e == 5'd0) begin
      if (m != 10'd0) widened = {h[15], ew, nm[9:0], 13'd0};
    end else if (e == hsfc_pkg::HalfExpMax) begin
      widened = {h[15], 8'hFF, m, 13'd0};
    end else begin
      widened = {h[15], 8'({3'd0, e} + 8'(hsfc_pkg::ExpBiasDiff)), m, 13'd0};
    end
  end

  // single to half, round to nearest even
  always_comb begin
    logic        s;
    logic [7:0]  e;
    logic [22:0] f;
    logic [8:0]  e16;
    logic [23:0] full;
    logic [4:0]  sh;
    logic [23:0] sub_m;
    logic [31:0] rem;
    logic [31:0] hlf;
    logic [10:0] mr;
    logic [15:0] inf;
    s   = beat_i.operand[31];
    e   = beat_i.operand[30:23];
    f   = beat_i.operand[22:0];
    inf = {s, hsfc_pkg::HalfExpMax, 10'd0};
    e16 = {1'b0, e} - 9'(hsfc_pkg::ExpBiasDiff);
    full = {1'b1, f};
    // subnormal shift: 14 - e16, valid when e16 <= 0 (up to 30 bits dropped)
    sh  = 5'(9'd14 - e16);
    sub_m = full >> sh;
    hlf   = 32'd1 << (sh - 5'd1);
    rem   = {8'd0, full} & ((32'd1 << sh) - 32'd1);
    mr    = 11'd0;
    if (e == 8'hFF) begin
      narrowed = (f == 23'd0) ? inf : (inf | {6'd0, hsfc_pkg::HalfQnanBit});
    end else if (e == 8'd0) begin
      narrowed = {s, 15'd0};
    end else if (e > 8'd142) begin
      narrowed = inf;
    end else if (e <= 8'd112) begin
      if (e < 8'd96) begin
        narrowed = {s, 15'd0};
      end else begin
        mr = sub_m[10:0];
        if (rem > hlf || (rem == hlf && sub_m[0])) mr = mr + 11'd1;
        narrowed = {s, 4'd0, mr};
      end
    end else begin
      mr = {1'b0, f[22:13]};
      if (f[12:0] > hsfc_pkg::DropHalf || (f[12:0] == hsfc_pkg::DropHalf && f[13]))
        mr = mr + 11'd1;
      // carry rolls into exponent; 30 + carry gives infinity pattern
      narrowed = {s, 15'({e16[4:0], 10'd0} + {4'd0, mr})};
    end
  end

  assign converted_o = (beat_i.op == hsfc_pkg::OP_HALF_TO_SINGLE) ?
                       widened : {16'd0, narrowed};

endmodule

`default_nettype wire

// ===== sv/half_single_float_converter.sv =====
// ----------------------------------------------------------------------------
// half_single_float_converter
// IEEE 754 binary16/binary32 bit-pattern converter, one beat per cycle.
// ----------------------------------------------------------------------------
// Usage:
//   in_if carries op and operand; op selects half->single or single->half.
//   out_if carries the converted pattern; a half result is zero-extended.
//   Path: an input beat is registered in the input register, converted
//   combinationally, and registered into the output register when the
//   output stage advances. Throughput: one beat per cycle while the receiver
//   does not stall; the input register and the output register form a
//   two-entry pipeline, each stage advances when the one ahead is empty or draining.
//   Reset clears both valid flags; nothing else is held.
//   When the receiver stalls, the output beat holds, the input stage fills,
//   and in_if.ready drops until the output is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module half_single_float_converter (
  input  wire          clk_i,
  input  wire          rst_ni,
  hsfc_in_if.sink      in_if,
  hsfc_out_if.source   out_if
);

  logic               in_vld_q;
  hsfc_pkg::in_beat_t in_q;
  logic               out_vld_q;
  logic [31:0]        out_q;
  logic [31:0]        conv;
  logic               out_adv;
  logic               in_adv;

  hsfc_convert u_convert (
    .beat_i      (in_q),
    .converted_o (conv)
  );

  assign out_adv      = !out_vld_q || out_if.ready;
  assign in_adv       = !in_vld_q || out_adv;
  assign in_if.ready  = in_adv;
  assign out_if.valid = out_vld_q;
  assign out_if.payload.converted = out_q;

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (out_adv) out_vld_q <= in_vld_q;
      if (in_adv)  in_vld_q  <= in_if.valid;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (in_adv && in_if.valid) in_q <= in_if.payload;
    if (out_adv && in_vld_q)   out_q <= conv;
  end

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_if.ready |=> out_vld_q && $stable(out_q))
    else $error("output beat lost under stall");
  a_move: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_vld_q && out_adv |=> out_vld_q && out_q == $past(conv))
    else $error("converted beat not registered");
  a_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> in_vld_q && out_vld_q)
    else $error("ready low with free stage");

endmodule

`default_nettype wire
